FILE: rtl/core/ccsr_pkg.sv
package ccsr_pkg;

    localparam int MaxRows = 64;
    localparam int MaxCols = 64;
    localparam int RowW = $clog2(MaxRows);
    localparam int ColW = $clog2(MaxCols);
    localparam int AddrW = RowW + ColW;
    localparam int Depth = MaxRows * MaxCols;
    localparam logic [7:0] SpaceChar = 8'h20;

    localparam logic [2:0] OpClear = 3'd0;
    localparam logic [2:0] OpPoint = 3'd1;
    localparam logic [2:0] OpCircle = 3'd2;
    localparam logic [2:0] OpDisc = 3'd3;
    localparam logic [2:0] OpRect = 3'd4;
    localparam logic [2:0] OpFill = 3'd5;
    localparam logic [2:0] OpLine = 3'd6;
    localparam logic [2:0] OpRead = 3'd7;

    localparam logic RegRows = 1'b0;
    localparam logic RegCols = 1'b1;

    typedef struct packed {
        logic [2:0] op;
        logic signed [7:0] a_row;
        logic signed [7:0] a_col;
        logic [6:0] b_row;
        logic [6:0] b_col;
        logic [6:0] radius;
        logic [7:0] ch;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_char;
        logic status;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture command, reset scan
        logic step;     // one pixel / line step
        logic read_req; // issue store read
        logic read_cap; // capture read data
        logic wipe;     // clearing pass write of reset sweep
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;       // scan or line finished at this step
        logic single;     // command takes no scan (point, rejected line, empty scan)
        logic is_read;
        logic wipe_last;
    } dp_stat_t;

endpackage

FILE: rtl/core/ccsr_ctrl.sv
module ccsr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ccsr_pkg::dp_cmd_t    cmd,
    input  ccsr_pkg::dp_stat_t   stat
);

    typedef enum logic [5:0] {
        S_WIPE = 6'b000001,
        S_IDLE = 6'b000010,
        S_DEC  = 6'b000100,
        S_RUN  = 6'b001000,
        S_RD   = 6'b010000,
        S_RDC  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // free output slot: empty or being taken this cycle
    logic slot_free;
    assign slot_free = !out_valid_reg || !out_stall;

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        unique case (state_reg)
            S_WIPE:
            begin
                cmd.wipe = 1'b1;
                if (stat.wipe_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.is_read)
                begin
                    cmd.read_req = 1'b1;
                    state_next = S_RD;
                end
                else
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last || stat.single)
                    state_next = S_RDC;
            end
            S_RD:
            begin
                cmd.read_cap = 1'b1;
                state_next = S_RDC;
            end
            S_RDC:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("result dropped");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("load outside idle");

endmodule

FILE: rtl/core/ccsr_dp.sv
module ccsr_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccsr_pkg::in_word_t   in_word,
    input  logic                 cfg_valid,
    input  logic                 cfg_index,
    input  logic [6:0]           cfg_data,
    input  ccsr_pkg::dp_cmd_t    cmd,
    output ccsr_pkg::dp_stat_t   stat,
    input  logic                 out_load,
    output ccsr_pkg::out_word_t  out_word
);

    localparam int RW = ccsr_pkg::RowW;
    localparam int CW = ccsr_pkg::ColW;

    logic [6:0] rows_reg, cols_reg;
    ccsr_pkg::in_word_t cmd_reg;
    logic [RW:0] r_reg, r_next;
    logic [CW:0] c_reg, c_next;
    logic [RW:0] nr;
    logic [CW:0] nc;
    logic signed [9:0] lrow_reg, lcol_reg;
    logic signed [10:0] dec_reg;
    logic [7:0] mem [ccsr_pkg::Depth];
    logic [7:0] rdata_reg;
    logic [ccsr_pkg::AddrW-1:0] wipe_reg;
    logic reject_reg, rd_in_reg;
    logic [7:0] res_char_reg;
    logic res_st_reg;

    // effective canvas
    assign nr = (rows_reg > 7'(ccsr_pkg::MaxRows)) ? (RW+1)'(ccsr_pkg::MaxRows) : rows_reg[RW:0];
    assign nc = (cols_reg > 7'(ccsr_pkg::MaxCols)) ? (CW+1)'(ccsr_pkg::MaxCols) : cols_reg[CW:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 7'd64;
            cols_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ccsr_pkg::RegRows)
                rows_reg <= cfg_data;
            else
                cols_reg <= cfg_data;
        end
    end

    // circle distance terms
    logic signed [9:0] di, dj;
    logic signed [19:0] dsq;
    logic signed [8:0] rm1, rp1;
    logic signed [19:0] lo_b, hi_b, rr;
    assign di = 10'(signed'({1'b0, r_reg})) - 10'(cmd_reg.a_row);
    assign dj = 10'(signed'({1'b0, c_reg})) - 10'(cmd_reg.a_col);
    assign dsq = di * di + dj * dj;
    assign rm1 = 9'(signed'({2'b0, cmd_reg.radius})) - 9'sd1;
    assign rp1 = 9'(signed'({2'b0, cmd_reg.radius})) + 9'sd1;
    assign lo_b = 20'(rm1 * rm1);
    assign hi_b = 20'(rm1 * rp1);
    assign rr = 20'(signed'({1'b0, cmd_reg.radius}) * signed'({1'b0, cmd_reg.radius}));

    // rect scan bounds
    logic [RW:0] r0;
    logic [CW:0] c0;
    logic signed [9:0] rend, cend;
    assign r0 = cmd_reg.a_row[7] ? '0 : (RW+1)'(cmd_reg.a_row);
    assign c0 = cmd_reg.a_col[7] ? '0 : (CW+1)'(cmd_reg.a_col);
    assign rend = ($signed({3'b0, cmd_reg.b_row}) < $signed({3'b0, nr}))
        ? $signed({3'b0, cmd_reg.b_row}) : $signed(10'(nr));
    assign cend = ($signed({3'b0, cmd_reg.b_col}) < $signed({3'b0, nc}))
        ? $signed({3'b0, cmd_reg.b_col}) : $signed(10'(nc));

    logic is_scan_full, is_rect, is_line;
    assign is_scan_full = (cmd_reg.op == ccsr_pkg::OpClear) || (cmd_reg.op == ccsr_pkg::OpCircle)
        || (cmd_reg.op == ccsr_pkg::OpDisc);
    assign is_rect = (cmd_reg.op == ccsr_pkg::OpRect) || (cmd_reg.op == ccsr_pkg::OpFill);
    assign is_line = (cmd_reg.op == ccsr_pkg::OpLine);

    logic signed [9:0] ldr, ldc;
    logic line_bad;
    assign ldr = 10'(signed'({1'b0, cmd_reg.b_row})) - 10'(cmd_reg.a_row);
    assign ldc = 10'(signed'({1'b0, cmd_reg.b_col})) - 10'(cmd_reg.a_col);
    assign line_bad = (ldc < 0) || (ldc > ldr);

    logic rect_empty;
    assign rect_empty = ($signed(10'(r0)) >= rend) || ($signed(10'(c0)) >= cend);

    // write decision for current position
    logic hit, we, in_lp;
    logic [7:0] wval;
    logic [RW-1:0] wr;
    logic [CW-1:0] wc;
    logic scan_last;
    assign in_lp = (lrow_reg >= 0) && (lcol_reg >= 0) && (lrow_reg < $signed(10'(nr)))
        && (lcol_reg < $signed(10'(nc)));

    always_comb
    begin
        hit = 1'b0;
        wval = cmd_reg.ch;
        wr = r_reg[RW-1:0];
        wc = c_reg[CW-1:0];
        scan_last = 1'b0;
        case (cmd_reg.op)
            ccsr_pkg::OpClear:
            begin
                hit = 1'b1;
                wval = ccsr_pkg::SpaceChar;
            end
            ccsr_pkg::OpCircle: hit = (dsq >= lo_b) && (dsq <= hi_b);
            ccsr_pkg::OpDisc:   hit = (dsq <= rr);
            ccsr_pkg::OpRect:
                hit = ($signed(10'(r_reg)) == 10'(cmd_reg.a_row))
                    || ($signed(10'(r_reg)) == $signed({3'b0, cmd_reg.b_row}) - 10'sd1)
                    || ($signed(10'(c_reg)) == 10'(cmd_reg.a_col))
                    || ($signed(10'(c_reg)) == $signed({3'b0, cmd_reg.b_col}) - 10'sd1);
            ccsr_pkg::OpFill:   hit = 1'b1;
            ccsr_pkg::OpPoint, ccsr_pkg::OpLine:
            begin
                hit = in_lp;
                wr = lrow_reg[RW-1:0];
                wc = lcol_reg[CW-1:0];
            end
            default: hit = 1'b0;
        endcase
        if (is_scan_full)
            scan_last = (c_reg == nc - 1'b1) && (r_reg == nr - 1'b1);
        else if (is_rect)
            scan_last = ($signed(10'(c_reg)) == cend - 10'sd1)
                && ($signed(10'(r_reg)) == rend - 10'sd1);
        else
            scan_last = (lrow_reg == $signed({3'b0, cmd_reg.b_row}));
    end

    logic scan_empty;
    assign scan_empty = (is_scan_full && (nr == '0 || nc == '0)) || (is_rect && rect_empty);
    assign we = cmd.step && hit && !reject_reg && !scan_empty && !(is_line && line_bad);

    assign stat.last = scan_last;
    assign stat.single = (cmd_reg.op == ccsr_pkg::OpPoint) || (is_line && line_bad) || scan_empty;
    assign stat.is_read = (cmd_reg.op == ccsr_pkg::OpRead);
    assign stat.wipe_last = (wipe_reg == '1);

    always_comb
    begin
        r_next = r_reg;
        c_next = c_reg;
        if (cmd.step)
        begin
            if (is_scan_full)
            begin
                if (c_reg == nc - 1'b1)
                begin
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                end
                else
                    c_next = c_reg + 1'b1;
            end
            else if (is_rect)
            begin
                if ($signed(10'(c_reg)) == cend - 10'sd1)
                begin
                    c_next = c0;
                    r_next = r_reg + 1'b1;
                end
                else
                    c_next = c_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_reg <= '0;
            reject_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wipe)
                wipe_reg <= wipe_reg + 1'b1;
            if (cmd.load)
                reject_reg <= 1'b0;
            else if (cmd.step && is_line && line_bad)
                reject_reg <= 1'b1;
        end
    end

    // scan position, line state
    logic first_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_word;
            first_reg <= 1'b1;
            rd_in_reg <= 1'b0;
        end
        else if (first_reg)
        begin
            first_reg <= 1'b0;
            r_reg <= is_scan_full ? '0 : r0;
            c_reg <= is_scan_full ? '0 : c0;
            lrow_reg <= 10'(cmd_reg.a_row);
            lcol_reg <= 10'(cmd_reg.a_col);
            dec_reg <= 11'(2 * ldc - ldr);
            rd_in_reg <= (cmd_reg.a_row >= 0) && (cmd_reg.a_col >= 0)
                && ($signed(10'(cmd_reg.a_row)) < $signed(10'(nr)))
                && ($signed(10'(cmd_reg.a_col)) < $signed(10'(nc)));
        end
        else if (cmd.step)
        begin
            r_reg <= r_next;
            c_reg <= c_next;
            lrow_reg <= lrow_reg + 10'sd1;
            if (dec_reg > 0)
            begin
                lcol_reg <= lcol_reg + 10'sd1;
                dec_reg <= dec_reg - 11'(2 * ldr) + 11'(2 * ldc);
            end
            else
                dec_reg <= dec_reg + 11'(2 * ldc);
        end
        if (cmd.load)
        begin
            res_char_reg <= 8'd0;
            res_st_reg <= 1'b0;
        end
        else if (cmd.read_cap)
            res_char_reg <= rd_in_reg ? rdata_reg : 8'd0;
        else if (cmd.step && is_line && line_bad)
            res_st_reg <= 1'b1;
    end

    // pixel store
    always_ff @(posedge clk)
    begin
        if (cmd.wipe)
            mem[wipe_reg] <= ccsr_pkg::SpaceChar;
        else if (we)
            mem[{wr, wc}] <= wval;
        if (cmd.read_req)
            rdata_reg <= mem[{cmd_reg.a_row[RW-1:0], cmd_reg.a_col[CW-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word.read_char <= res_char_reg;
            out_word.status <= res_st_reg;
        end
    end

    a_no_wr_wipe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wipe |-> !we)
        else $error("write during wipe");
    a_line_rej: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && is_line && line_bad) |-> !we)
        else $error("rejected line wrote");
    a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.step && !cmd.wipe)
        else $error("load overlaps work");

endmodule

FILE: rtl/core/char_canvas_shape_rasterizer.sv
// Character canvas rasterizer: a 64x64 store of 8-bit codes, swept to spaces by a
// clearing pass after reset (commands are stalled meanwhile). One command at a time,
// one result word per command. Point and read need no scan; rectangles step through
// each pixel in the clipped span, lines through each row, and clear and circles
// through each pixel of the canvas in use (up to 4096), all set by the single
// write port of the pixel store.
module char_canvas_shape_rasterizer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ccsr_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ccsr_pkg::out_word_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [6:0]           cfg_data
);

    ccsr_pkg::dp_cmd_t cmd;
    ccsr_pkg::dp_stat_t stat;
    logic out_load;

    assign cfg_ready = 1'b1;
    assign out_load = !out_valid || !out_stall;

    ccsr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .stat(stat)
    );

    ccsr_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_word(in_data),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .stat(stat),
        .out_load(out_load), .out_word(out_data)
    );

endmodule

FILE: tb/sv/tb_char_canvas_shape_rasterizer.sv
module tb_char_canvas_shape_rasterizer;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    ccsr_pkg::in_word_t   in_data;
    logic                 out_valid;
    logic                 out_stall;
    ccsr_pkg::out_word_t  out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [6:0]           cfg_data;

    char_canvas_shape_rasterizer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [7:0]           canvas [0:ccsr_pkg::MaxRows*ccsr_pkg::MaxCols-1];
    int                   canvas_rows;
    int                   canvas_cols;
    ccsr_pkg::out_word_t  pending_words [$];
    int                   mismatches;
    int                   sent_words;
    int                   got_words;
    int                   idle_cycles;
    int                   send_gap_pct;
    int                   recv_stall_pct;
    bit                   timed_out;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit on_canvas(int r, int c);
        int nr;
        int nc;
        nr = canvas_rows > ccsr_pkg::MaxRows ? ccsr_pkg::MaxRows : canvas_rows;
        nc = canvas_cols > ccsr_pkg::MaxCols ? ccsr_pkg::MaxCols : canvas_cols;
        return r >= 0 && c >= 0 && r < nr && c < nc;
    endfunction

    function automatic void plot(int r, int c, logic [7:0] v);
        if (on_canvas(r, c))
            canvas[r*ccsr_pkg::MaxCols + c] = v;
    endfunction

    function automatic ccsr_pkg::out_word_t draw_command(ccsr_pkg::in_word_t w);
        ccsr_pkg::out_word_t res;
        int ar;
        int ac;
        int br;
        int bc;
        int rad;
        int d;
        int dr;
        int dc;
        int dec;
        int col;
        bit hit;
        ar = w.a_row;
        ac = w.a_col;
        br = w.b_row;
        bc = w.b_col;
        rad = w.radius;
        res = '0;
        case (w.op)
            ccsr_pkg::OpClear:
                for (int i = 0; i < ccsr_pkg::MaxRows; i++)
                    for (int j = 0; j < ccsr_pkg::MaxCols; j++)
                        plot(i, j, ccsr_pkg::SpaceChar);
            ccsr_pkg::OpPoint:
                plot(ar, ac, w.ch);
            ccsr_pkg::OpCircle, ccsr_pkg::OpDisc:
                for (int i = 0; i < ccsr_pkg::MaxRows; i++)
                    for (int j = 0; j < ccsr_pkg::MaxCols; j++)
                    begin
                        d = (i-ar)*(i-ar) + (j-ac)*(j-ac);
                        if (w.op == ccsr_pkg::OpCircle)
                            hit = d >= (rad-1)*(rad-1) && d <= (rad-1)*(rad+1);
                        else
                            hit = d <= rad*rad;
                        if (hit)
                            plot(i, j, w.ch);
                    end
            ccsr_pkg::OpRect, ccsr_pkg::OpFill:
                for (int i = (ar < 0 ? 0 : ar); i < br; i++)
                    for (int j = (ac < 0 ? 0 : ac); j < bc; j++)
                        if (w.op == ccsr_pkg::OpFill || i == ar || i == br-1
                            || j == ac || j == bc-1)
                            plot(i, j, w.ch);
            ccsr_pkg::OpLine:
            begin
                dr = br - ar;
                dc = bc - ac;
                if (dc < 0 || dc > dr)
                    res.status = 1'b1;
                else
                begin
                    dec = 2*dc - dr;
                    col = ac;
                    for (int i = ar; i <= br; i++)
                    begin
                        plot(i, col, w.ch);
                        if (dec > 0)
                        begin
                            col++;
                            dec -= 2*dr;
                        end
                        dec += 2*dc;
                    end
                end
            end
            default:
                if (on_canvas(ar, ac))
                    res.read_char = canvas[ar*ccsr_pkg::MaxCols + ac];
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                got_words++;
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word read_char=%h status=%b",
                                 out_data.read_char, out_data.status);
                end
                else
                begin
                    ccsr_pkg::out_word_t exp_w;
                    exp_w = pending_words.pop_front();
                    if (exp_w.read_char !== out_data.read_char
                        || exp_w.status !== out_data.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: expected read_char=%h status=%b, got %h %b",
                                     got_words, exp_w.read_char, exp_w.status,
                                     out_data.read_char, out_data.status);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // clearing pass plus full-canvas scans fit well inside this
    always @(posedge clk)
    begin
        if (idle_cycles > 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_word(ccsr_pkg::in_word_t w);
        while ($urandom_range(99) < send_gap_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_words.push_back(draw_command(w));
        sent_words++;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_cmd(logic [2:0] op, int ar, int ac, int br, int bc, int rad,
                            int ch);
        ccsr_pkg::in_word_t w;
        w.op = op;
        w.a_row = ar[7:0];
        w.a_col = ac[7:0];
        w.b_row = br[6:0];
        w.b_col = bc[6:0];
        w.radius = rad[6:0];
        w.ch = ch[7:0];
        send_word(w);
    endtask

    task automatic drain();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4200) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[6:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == ccsr_pkg::RegRows)
            canvas_rows = value & 'h7f;
        else
            canvas_cols = value & 'h7f;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_cmd(ccsr_pkg::OpRead, 0, 0, 0, 0, 0, 0);
        send_cmd(ccsr_pkg::OpPoint, 0, 0, 0, 0, 0, 8'hff);
        send_cmd(ccsr_pkg::OpPoint, 63, 63, 0, 0, 0, 8'h00);
        send_cmd(ccsr_pkg::OpPoint, -128, 127, 0, 0, 0, 8'h55);
        send_cmd(ccsr_pkg::OpRead, 0, 0, 0, 0, 0, 0);
        send_cmd(ccsr_pkg::OpRead, 63, 63, 0, 0, 0, 0);
        send_cmd(ccsr_pkg::OpRead, -1, 127, 0, 0, 0, 0);
        send_cmd(ccsr_pkg::OpCircle, 20, 20, 0, 0, 0, 8'h41);
        send_cmd(ccsr_pkg::OpCircle, 30, 30, 0, 0, 10, 8'h42);
        send_cmd(ccsr_pkg::OpDisc, -5, 70, 0, 0, 127, 8'haa);
        send_cmd(ccsr_pkg::OpDisc, 10, 10, 0, 0, 0, 8'h43);
        send_cmd(ccsr_pkg::OpRect, 2, 3, 12, 20, 0, 8'h44);
        send_cmd(ccsr_pkg::OpFill, -128, -128, 64, 64, 0, 8'h45);
        send_cmd(ccsr_pkg::OpRect, 10, 10, 5, 5, 0, 8'h46);
        send_cmd(ccsr_pkg::OpFill, 5, 5, 6, 6, 0, 8'h47);
        send_cmd(ccsr_pkg::OpLine, 0, 0, 63, 20, 0, 8'h48);
        send_cmd(ccsr_pkg::OpLine, 0, 0, 64, 64, 0, 8'h49);
        send_cmd(ccsr_pkg::OpLine, 10, 10, 20, 30, 0, 8'h4a);
        send_cmd(ccsr_pkg::OpLine, 10, 10, 20, 5, 0, 8'h4b);
        send_cmd(ccsr_pkg::OpLine, 127, -128, 0, 0, 0, 8'h4c);
        send_cmd(ccsr_pkg::OpLine, -3, 60, 64, 64, 0, 8'h4d);
        send_cmd(ccsr_pkg::OpRead, 0, 63, 0, 0, 0, 0);
        send_cmd(ccsr_pkg::OpClear, 0, 0, 0, 0, 0, 0);
        send_cmd(ccsr_pkg::OpRead, 5, 5, 0, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        int op;
        int ar;
        int ac;
        int br;
        for (int k = 0; k < count; k++)
        begin
            op = $urandom_range(99) < 10 ? $urandom_range(7) :
                 ($urandom_range(99) < 40 ? ccsr_pkg::OpRead : $urandom_range(7));
            if (op == ccsr_pkg::OpClear && $urandom_range(3) != 0)
                op = ccsr_pkg::OpPoint;
            if ($urandom_range(9) == 0)
            begin
                ar = $urandom_range(255) - 128;
                ac = $urandom_range(255) - 128;
            end
            else
            begin
                ar = $urandom_range(66) - 2;
                ac = $urandom_range(66) - 2;
            end
            br = $urandom_range(64);
            if (op == ccsr_pkg::OpLine && $urandom_range(3) != 0 && ar >= 0 && ar < 64)
            begin
                br = $urandom_range(64, ar);
                send_cmd(3'(op), ar, ac, br, ac + $urandom_range(br - ar), 0, $urandom);
            end
            else
                send_cmd(3'(op), ar, ac, br, $urandom_range(64),
                         $urandom_range(99) < 90 ? $urandom_range(20) : $urandom_range(127),
                         $urandom);
        end
    endtask

    task automatic test_config();
        write_reg(ccsr_pkg::RegRows, 1);
        write_reg(ccsr_pkg::RegCols, 64);
        test_random(8);
        drain();
        write_reg(ccsr_pkg::RegRows, 127);
        write_reg(ccsr_pkg::RegCols, 1);
        test_random(8);
        drain();
        write_reg(ccsr_pkg::RegRows, 0);
        write_reg(ccsr_pkg::RegCols, 0);
        test_random(6);
        drain();
        write_reg(ccsr_pkg::RegRows, 17);
        write_reg(ccsr_pkg::RegCols, 40);
        test_random(10);
        drain();
        write_reg(ccsr_pkg::RegRows, 64);
        write_reg(ccsr_pkg::RegCols, 64);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        sent_words = 0;
        got_words = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        send_gap_pct = 8;
        recv_stall_pct = 83;
        canvas_rows = 64;
        canvas_cols = 64;
        for (int i = 0; i < ccsr_pkg::MaxRows*ccsr_pkg::MaxCols; i++)
            canvas[i] = ccsr_pkg::SpaceChar;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain();
        test_config();
        test_random(35);
        send_gap_pct = 83;
        recv_stall_pct = 8;
        test_random(35);
        drain();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(15);

        drain();
        $display("ran %0d commands over all ops, clipping and canvas sizes; %0d words checked",
                 sent_words, got_words);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
